// ===== rtl/dqmb_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS query message builder package
// Shared widths, constants, command and status types of the builder.
// ----------------------------------------------------------------------------
package dqmb_pkg;

  localparam int LABEL_DEPTH_DEF = 63;
  localparam int LEN_W           = 6;
  localparam int STEP_W          = 6;
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 16;
  localparam int OUT_USER_W      = 2;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Fixed 12-byte header: id, flags, question count, three empty counts.
  localparam int          HDR_WORDS  = 6;
  localparam logic [15:0] HDR_ID     = 16'h0001;
  localparam logic [15:0] HDR_FLAGS  = 16'h0100;
  localparam logic [15:0] HDR_QDCNT  = 16'h0001;
  localparam logic [2:0]  HW_ID      = 3'd0;
  localparam logic [2:0]  HW_FLAGS   = 3'd1;
  localparam logic [2:0]  HW_QDCNT   = 3'd2;

  // Closing bytes after the last label.
  localparam logic [2:0] TB_ZERO     = 3'd0;
  localparam logic [2:0] TB_TYPE_HI  = 3'd1;
  localparam logic [2:0] TB_TYPE_LO  = 3'd2;
  localparam logic [2:0] TB_CLASS_HI = 3'd3;
  localparam logic [2:0] TB_CLASS_LO = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_HDR,
    OP_CHAR,
    OP_PUT_LEN,
    OP_RD,
    OP_PUT_MEM,
    OP_PUT_TAIL,
    OP_ODD
  } dqmb_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_CHAR,
    ST_ENDCHK,
    ST_FLEN,
    ST_FRD,
    ST_FPUT,
    ST_TAIL,
    ST_ODD
  } dqmb_state_t;

  typedef struct packed {
    dqmb_op_t            op;
    logic [STEP_W-1:0]   step;
    logic                last;
    logic                clr_len;
  } dqmb_cmd_t;

  typedef struct packed {
    logic               started;
    logic               char_valid;
    logic               name_end;
    logic               is_dot;
    logic [LEN_W-1:0]   len;
    logic               held;
    logic               out_free;
  } dqmb_sts_t;

  function automatic logic [15:0] hdr_word(input logic [2:0] idx);
    logic [15:0] w;
    w = 16'h0000;
    case (idx)
      HW_ID:    w = HDR_ID;
      HW_FLAGS: w = HDR_FLAGS;
      HW_QDCNT: w = HDR_QDCNT;
      default:  w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dqmb_ctrl.sv =====
// ----------------------------------------------------------------------------
// DNS query message builder controller
// Sequences header, character handling, label flush and message tail.
// ----------------------------------------------------------------------------
module dqmb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_char_valid,
  input  logic                 in_name_end,
  output logic                 in_tready,
  input  dqmb_pkg::dqmb_sts_t  sts,
  output dqmb_pkg::dqmb_cmd_t  cmd
);

  dqmb_pkg::dqmb_state_t           state_r, state_nxt;
  logic [dqmb_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [dqmb_pkg::STEP_W-1:0]     step_inc;
  logic                            put_ok;
  logic                            mem_last;

  assign step_inc = dqmb_pkg::STEP_W'(step_r + 1'b1);
  // A byte that pairs with a held byte produces a word and needs the output free.
  assign put_ok   = !sts.held || sts.out_free;
  assign mem_last = (step_inc == dqmb_pkg::STEP_W'(sts.len));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqmb_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      dqmb_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (in_tvalid && (in_char_valid || in_name_end)) begin
          state_nxt = sts.started ? dqmb_pkg::ST_CHAR : dqmb_pkg::ST_HDR;
        end
      end
      dqmb_pkg::ST_HDR: begin
        if (sts.out_free) begin
          if (step_r == dqmb_pkg::STEP_W'(dqmb_pkg::HDR_WORDS - 1)) begin
            state_nxt = dqmb_pkg::ST_CHAR;
            step_nxt  = '0;
          end else begin
            step_nxt = step_inc;
          end
        end
      end
      dqmb_pkg::ST_CHAR: begin
        if (sts.char_valid && sts.is_dot) begin
          state_nxt = dqmb_pkg::ST_FLEN;
        end else if (sts.name_end) begin
          state_nxt = dqmb_pkg::ST_ENDCHK;
        end else begin
          state_nxt = dqmb_pkg::ST_IDLE;
        end
      end
      dqmb_pkg::ST_ENDCHK: begin
        step_nxt = '0;
        if (!sts.name_end) begin
          state_nxt = dqmb_pkg::ST_IDLE;
        end else if (sts.len != '0) begin
          state_nxt = dqmb_pkg::ST_FLEN;
        end else begin
          state_nxt = dqmb_pkg::ST_TAIL;
        end
      end
      dqmb_pkg::ST_FLEN: begin
        step_nxt = '0;
        if (put_ok) begin
          state_nxt = (sts.len == '0) ? dqmb_pkg::ST_ENDCHK : dqmb_pkg::ST_FRD;
        end
      end
      dqmb_pkg::ST_FRD: begin
        state_nxt = dqmb_pkg::ST_FPUT;
      end
      dqmb_pkg::ST_FPUT: begin
        if (put_ok) begin
          if (mem_last) begin
            state_nxt = dqmb_pkg::ST_ENDCHK;
            step_nxt  = '0;
          end else begin
            state_nxt = dqmb_pkg::ST_FRD;
            step_nxt  = step_inc;
          end
        end
      end
      dqmb_pkg::ST_TAIL: begin
        if (put_ok) begin
          if (step_r == dqmb_pkg::STEP_W'(dqmb_pkg::TB_CLASS_LO)) begin
            state_nxt = sts.held ? dqmb_pkg::ST_IDLE : dqmb_pkg::ST_ODD;
            step_nxt  = '0;
          end else begin
            step_nxt = step_inc;
          end
        end
      end
      dqmb_pkg::ST_ODD: begin
        if (sts.out_free) begin
          state_nxt = dqmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dqmb_pkg::ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = dqmb_pkg::OP_NONE;
    cmd.step    = step_r;
    in_tready   = 1'b0;
    unique case (state_r)
      dqmb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = dqmb_pkg::OP_CAPTURE;
      end
      dqmb_pkg::ST_HDR: begin
        if (sts.out_free) cmd.op = dqmb_pkg::OP_HDR;
      end
      dqmb_pkg::ST_CHAR: begin
        cmd.op = dqmb_pkg::OP_CHAR;
      end
      dqmb_pkg::ST_ENDCHK: begin
        cmd.op = dqmb_pkg::OP_NONE;
      end
      dqmb_pkg::ST_FLEN: begin
        if (put_ok) cmd.op = dqmb_pkg::OP_PUT_LEN;
      end
      dqmb_pkg::ST_FRD: begin
        cmd.op = dqmb_pkg::OP_RD;
      end
      dqmb_pkg::ST_FPUT: begin
        if (put_ok) begin
          cmd.op      = dqmb_pkg::OP_PUT_MEM;
          cmd.clr_len = mem_last;
        end
      end
      dqmb_pkg::ST_TAIL: begin
        if (put_ok) begin
          cmd.op   = dqmb_pkg::OP_PUT_TAIL;
          cmd.last = (step_r == dqmb_pkg::STEP_W'(dqmb_pkg::TB_CLASS_LO));
        end
      end
      dqmb_pkg::ST_ODD: begin
        if (sts.out_free) begin
          cmd.op   = dqmb_pkg::OP_ODD;
          cmd.last = 1'b1;
        end
      end
      default: begin
        cmd.op = dqmb_pkg::OP_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/dqmb_dp.sv =====
// ----------------------------------------------------------------------------
// DNS query message builder datapath
// Item capture, label buffer, byte-to-word packer and output register.
// ----------------------------------------------------------------------------
module dqmb_dp #(
  parameter int LABEL_DEPTH = dqmb_pkg::LABEL_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [dqmb_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [0:0]                         in_tuser,
  input  logic                               in_tlast,
  input  dqmb_pkg::dqmb_cmd_t                cmd,
  output dqmb_pkg::dqmb_sts_t                sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dqmb_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [dqmb_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                               out_tlast
);

  localparam int AW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam logic [dqmb_pkg::LEN_W-1:0] DEPTH_LEN = dqmb_pkg::LEN_W'(LABEL_DEPTH);

  logic [7:0] label_mem [LABEL_DEPTH];

  // Captured item.
  logic [7:0]  ch_r;
  logic        cvalid_r;
  logic        end_r;
  logic [15:0] qtype_r;
  logic [15:0] qclass_r;
  logic [7:0]  rd_data_r;

  logic [dqmb_pkg::LEN_W-1:0] len_r, len_nxt;
  logic started_r, started_nxt;
  logic [7:0] odd_r, odd_nxt;
  logic held_r, held_nxt;
  logic trunc_r, trunc_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_hi_r, out_lo_r;
  logic out_full_r, out_last_r, out_trunc_r;

  logic        is_dot;
  logic        char_wr;
  logic        is_put;
  logic [7:0]  put_byte;
  logic        emit;
  logic        emit_last;
  logic [7:0]  word_hi, word_lo;
  logic        word_full;
  logic [15:0] hdr_w;

  assign is_dot  = (ch_r == dqmb_pkg::DOT_CHAR);
  assign char_wr = (cmd.op == dqmb_pkg::OP_CHAR) && cvalid_r && !is_dot &&
                   (len_r < DEPTH_LEN);
  assign is_put  = (cmd.op == dqmb_pkg::OP_PUT_LEN) || (cmd.op == dqmb_pkg::OP_PUT_MEM) ||
                   (cmd.op == dqmb_pkg::OP_PUT_TAIL);
  assign hdr_w   = dqmb_pkg::hdr_word(cmd.step[2:0]);

  always_comb begin
    put_byte = 8'h00;
    unique case (cmd.op)
      dqmb_pkg::OP_PUT_LEN: put_byte = 8'(len_r);
      dqmb_pkg::OP_PUT_MEM: put_byte = rd_data_r;
      dqmb_pkg::OP_PUT_TAIL: begin
        case (cmd.step[2:0])
          dqmb_pkg::TB_TYPE_HI:  put_byte = qtype_r[15:8];
          dqmb_pkg::TB_TYPE_LO:  put_byte = qtype_r[7:0];
          dqmb_pkg::TB_CLASS_HI: put_byte = qclass_r[15:8];
          dqmb_pkg::TB_CLASS_LO: put_byte = qclass_r[7:0];
          default:               put_byte = 8'h00;
        endcase
      end
      default: put_byte = 8'h00;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    word_hi   = odd_r;
    word_lo   = 8'h00;
    word_full = 1'b1;
    odd_nxt   = odd_r;
    held_nxt  = held_r;
    if (cmd.op == dqmb_pkg::OP_HDR) begin
      emit    = 1'b1;
      word_hi = hdr_w[15:8];
      word_lo = hdr_w[7:0];
    end else if (cmd.op == dqmb_pkg::OP_ODD) begin
      emit      = 1'b1;
      word_full = 1'b0;
      held_nxt  = 1'b0;
      odd_nxt   = 8'h00;
    end else if (is_put) begin
      if (held_r) begin
        emit     = 1'b1;
        word_lo  = put_byte;
        held_nxt = 1'b0;
        odd_nxt  = 8'h00;
      end else begin
        odd_nxt  = put_byte;
        held_nxt = 1'b1;
      end
    end
  end

  assign emit_last = emit && cmd.last;

  always_comb begin
    len_nxt     = len_r;
    started_nxt = started_r;
    trunc_nxt   = trunc_r;
    if (char_wr) len_nxt = dqmb_pkg::LEN_W'(len_r + 1'b1);
    if (cmd.clr_len) len_nxt = '0;
    if (cmd.op == dqmb_pkg::OP_HDR) started_nxt = 1'b1;
    if ((cmd.op == dqmb_pkg::OP_CHAR) && cvalid_r && !is_dot && (len_r >= DEPTH_LEN)) begin
      trunc_nxt = 1'b1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
    // The final word returns the message state to its idle values.
    if (emit_last) begin
      len_nxt     = '0;
      started_nxt = 1'b0;
      trunc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      started_r   <= 1'b0;
      odd_r       <= 8'h00;
      held_r      <= 1'b0;
      trunc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      started_r   <= started_nxt;
      odd_r       <= odd_nxt;
      held_r      <= held_nxt;
      trunc_r     <= trunc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == dqmb_pkg::OP_CAPTURE) begin
      ch_r     <= in_tdata[7:0];
      qtype_r  <= in_tdata[23:8];
      qclass_r <= in_tdata[39:24];
      cvalid_r <= in_tuser[0];
      end_r    <= in_tlast;
    end
    if (emit) begin
      out_hi_r    <= word_hi;
      out_lo_r    <= word_lo;
      out_full_r  <= word_full;
      out_last_r  <= cmd.last;
      out_trunc_r <= cmd.last && trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (char_wr) begin
      label_mem[len_r[AW-1:0]] <= ch_r;
    end
    if (cmd.op == dqmb_pkg::OP_RD) begin
      rd_data_r <= label_mem[cmd.step[AW-1:0]];
    end
  end

  assign sts.started    = started_r;
  assign sts.char_valid = cvalid_r;
  assign sts.name_end   = end_r;
  assign sts.is_dot     = is_dot;
  assign sts.len        = len_r;
  assign sts.held       = held_r;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_lo_r, out_hi_r};
  assign out_tuser  = {out_trunc_r, out_full_r};
  assign out_tlast  = out_last_r;

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_last |=> (!held_r && !trunc_r && !started_r && (len_r == '0)))
    else $error("message state not cleared after final word");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= DEPTH_LEN)
    else $error("label length beyond buffer depth");

  a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_trunc_r) |-> out_last_r)
    else $error("truncation flag on a word that is not final");

  a_half_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_full_r) |-> out_last_r)
    else $error("half word before the end of the message");

  a_hdr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == dqmb_pkg::OP_HDR) |-> (!held_r && !out_valid_nxt == 1'b0))
    else $error("header word issued with a byte pending");

endmodule

// ===== rtl/dns_query_message_builder.sv =====
// ----------------------------------------------------------------------------
// DNS query message builder
// Turns a stream of domain-name characters into a DNS query message.
// ----------------------------------------------------------------------------
// The block takes one request per name character and sends the query message
// as 16-bit words, first message byte in the low byte of out_tdata. The first
// request of a message that carries a character or the end flag produces the
// 12-byte header first (6 words, one per cycle while the output is free). A
// dot flushes the buffered label: the length byte, then each label byte, read
// through the one registered port of the label buffer, and then a check for
// the end flag. The request with in_tlast set adds any pending label, then five
// closing bytes and an odd final byte if any. Labels longer than LABEL_DEPTH
// are cut, and the final word reports it in out_tuser[1]. A stall on the
// output side holds the builder until the word is taken.
module dns_query_message_builder #(
  parameter int LABEL_DEPTH = dqmb_pkg::LABEL_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] name_char, [23:8] query_type, [39:24] query_class
  input  logic [dqmb_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] char_valid
  input  logic [0:0]                         in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] word_high, [15:8] word_low
  output logic [dqmb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] word_full, [1] label_truncated
  output logic [dqmb_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                               out_tlast
);

  dqmb_pkg::dqmb_cmd_t cmd;
  dqmb_pkg::dqmb_sts_t sts;

  dqmb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_char_valid (in_tuser[0]),
    .in_name_end   (in_tlast),
    .in_tready     (in_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  dqmb_dp #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
